/* hdl/kwm_pkg.sv */
// ----------------------------------------------------------------------------
// kwm_pkg: shared definitions for the k-way sorted run merger
// Field widths, stream packing widths, the end sentinel and fixed limits.
// ----------------------------------------------------------------------------
package kwm_pkg;

  // Record field widths as they appear on the ports.
  localparam int WAY_W = 3;
  localparam int KEY_W = 32;
  localparam int PAY_W = 64;
  localparam int CFG_W = 4;

  // Stream data widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 96;

  // Key value that marks the end of a file; such records are never queued.
  localparam logic [KEY_W-1:0] SENTINEL_KEY = '1;

  // Reset value of the ways-in-use register.
  localparam logic [CFG_W-1:0] CFG_WAYS_RESET = 4'd8;

  // At most this many results leave for one accepted record.
  localparam int MAX_RESULTS = 32;
  localparam int RES_CNT_W   = 6;

  typedef logic [KEY_W-1:0] key_t;

endpackage

/* hdl/kway_sorted_run_merger.sv */
// ----------------------------------------------------------------------------
// kway_sorted_run_merger: merges up to WAYS sorted runs into one ascending run
// Per-way record queues in a shared memory, a sequencer that scans way heads
// through one key compare unit and emits the smallest record at a time.
// ----------------------------------------------------------------------------
// Records arrive one at a time, each tagged with its way. The block takes a
// record, then stays busy until every record it can release has been handed
// to the output register: it files the record, then before each release it
// scans the way heads and picks the smallest, reading the heads one per cycle
// from the single read port of the key memory into one 32-bit comparator; a
// last scan that finds nothing to release ends the turn, and any output stall
// adds to it. A record for a full queue is answered by one overflow result. A
// key of all ones is dropped. out_tlast marks the record that ends the merge.
module kway_sorted_run_merger #(
  parameter int WAYS         = 8,
  parameter int QUEUE_DEPTH  = 4,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration: ways_in_use.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kwm_pkg::CFG_W-1:0]      cfg_data,
  // Input records.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // in_tdata: way [2:0], key [34:3], payload [98:35], zero pad [103:99].
  input  logic [kwm_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                           in_tlast,   // way_last
  // Merged results.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_tdata: out_key [31:0], out_payload [95:32].
  output logic [kwm_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                           out_tlast,  // out_last
  output logic                           out_tuser   // overflow
);

  import kwm_pkg::*;

  // Derived sizes.
  localparam int WIW  = $clog2(WAYS);
  localparam int CNTW = $clog2(WAYS + 1);
  localparam int QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW   = $clog2(QUEUE_DEPTH + 1);
  localparam int SW   = FW + 1;
  localparam int AW   = WIW + QW;
  localparam int MEMD = WAYS * (2 ** QW);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_PICK   = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  // Control registers.
  logic [2:0]            state_r, state_nxt;
  logic [CFG_W-1:0]      cfg_ways_r;
  logic [FW-1:0]         fill_r  [WAYS];
  logic [QW-1:0]         head_r  [WAYS];
  logic [WAYS-1:0]       ended_r;
  logic [CNTW-1:0]       scan_idx_r, scan_idx_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic [WIW-1:0]        cmp_way_r, cmp_way_nxt;
  logic                  best_any_r, best_any_nxt;
  logic [RES_CNT_W-1:0]  res_cnt_r, res_cnt_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;

  // Payload registers.
  logic [WAY_W-1:0]        rec_way_r;
  key_t                    rec_key_r;
  logic [PAYLOAD_BITS-1:0] rec_pay_r;
  logic                    rec_last_r;
  key_t                    best_key_r, best_key_nxt;
  logic [WIW-1:0]          best_way_r, best_way_nxt;
  key_t                    key_rd_r;
  logic [PAYLOAD_BITS-1:0] pay_rd_r;
  key_t                    out_key_r;
  logic [PAYLOAD_BITS-1:0] out_pay_r;
  logic                    out_last_r;
  logic                    out_ovf_r;

  // Record queues, one region of 2**QW entries per way.
  key_t                    key_mem [MEMD];
  logic [PAYLOAD_BITS-1:0] pay_mem [MEMD];

  // Decoded controls.
  logic            in_xfer;
  logic            out_free;
  logic [CNTW-1:0] eff_ways;
  logic [WIW-1:0]  rec_idx;
  logic            rec_in_use;
  logic [SW-1:0]   slot_sum;
  logic [QW-1:0]   wr_slot;
  logic [AW-1:0]   key_rd_addr;
  logic            do_write;
  logic            set_ended;
  logic            do_pop;
  logic            clear_ended;
  logic            pay_rd_en;
  logic            all_ready;
  logic            done_now;
  logic            done_after_pop;
  logic            out_load;
  key_t            out_key_nxt;
  logic            out_last_nxt;
  logic            out_ovf_nxt;
  logic            out_pay_sel;

  assign in_xfer   = in_tvalid & in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = ~out_tvalid_r | out_tready;

  // Effective way count: zero acts as one, anything above WAYS as WAYS.
  always_comb begin
    if (cfg_ways_r == '0) begin
      eff_ways = CNTW'(1);
    end else if (int'(cfg_ways_r) > WAYS) begin
      eff_ways = CNTW'(WAYS);
    end else begin
      eff_ways = CNTW'(cfg_ways_r);
    end
  end

  // Target way of the held record and its free slot.
  assign rec_idx    = WIW'(rec_way_r);
  assign rec_in_use = int'(rec_way_r) < int'(eff_ways);
  assign slot_sum   = SW'(head_r[rec_idx]) + SW'(fill_r[rec_idx]);
  assign wr_slot    = (slot_sum >= SW'(QUEUE_DEPTH)) ? QW'(slot_sum - SW'(QUEUE_DEPTH))
                                                     : QW'(slot_sum);

  // Head read address during the scan.
  assign key_rd_addr = {scan_idx_r[WIW-1:0], head_r[scan_idx_r[WIW-1:0]]};

  // Merge status over the ways in use, one term per way.
  always_comb begin
    logic [FW-1:0] fill_left;
    all_ready      = 1'b1;
    done_now       = 1'b1;
    done_after_pop = 1'b1;
    for (int j = 0; j < WAYS; j++) begin
      fill_left = (WIW'(j) == best_way_r) ? fill_r[j] - FW'(1) : fill_r[j];
      if (CNTW'(j) < eff_ways) begin
        if (fill_r[j] == '0 && !ended_r[j]) begin
          all_ready = 1'b0;
        end
        if (!ended_r[j] || fill_r[j] != '0) begin
          done_now = 1'b0;
        end
        if (!ended_r[j] || fill_left != '0) begin
          done_after_pop = 1'b0;
        end
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    scan_idx_nxt   = scan_idx_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_way_nxt    = cmp_way_r;
    best_any_nxt   = best_any_r;
    best_key_nxt   = best_key_r;
    best_way_nxt   = best_way_r;
    res_cnt_nxt    = res_cnt_r;
    do_write       = 1'b0;
    set_ended      = 1'b0;
    do_pop         = 1'b0;
    clear_ended    = 1'b0;
    pay_rd_en      = 1'b0;
    out_load       = 1'b0;
    out_key_nxt    = '0;
    out_last_nxt   = 1'b0;
    out_ovf_nxt    = 1'b0;
    out_pay_sel    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        scan_idx_nxt = '0;
        cmp_vld_nxt  = 1'b0;
        best_any_nxt = 1'b0;
        res_cnt_nxt  = '0;
        state_nxt    = ST_SCAN;
        if (rec_in_use && !ended_r[rec_idx]) begin
          if (rec_key_r == SENTINEL_KEY) begin
            set_ended = rec_last_r;
          end else if (fill_r[rec_idx] == FW'(QUEUE_DEPTH)) begin
            // Queue full: answer with an overflow result once the output is free.
            if (out_free) begin
              out_load    = 1'b1;
              out_ovf_nxt = 1'b1;
              res_cnt_nxt = RES_CNT_W'(1);
            end else begin
              state_nxt = ST_DECIDE;
            end
          end else begin
            do_write  = 1'b1;
            set_ended = rec_last_r;
          end
        end
      end
      ST_SCAN: begin
        // Issue one head read per cycle and compare the previous one.
        if (scan_idx_r < eff_ways) begin
          cmp_vld_nxt  = 1'b1;
          cmp_way_nxt  = scan_idx_r[WIW-1:0];
          scan_idx_nxt = scan_idx_r + CNTW'(1);
        end else begin
          cmp_vld_nxt = 1'b0;
          if (!cmp_vld_r) begin
            state_nxt = ST_PICK;
          end
        end
        if (cmp_vld_r && fill_r[cmp_way_r] != '0) begin
          if (!best_any_r || key_rd_r < best_key_r) begin
            best_any_nxt = 1'b1;
            best_key_nxt = key_rd_r;
            best_way_nxt = cmp_way_r;
          end
        end
      end
      ST_PICK: begin
        if (all_ready && best_any_r && int'(res_cnt_r) < MAX_RESULTS) begin
          pay_rd_en = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          clear_ended = done_now;
          state_nxt   = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_key_nxt  = best_key_r;
          out_pay_sel  = 1'b1;
          out_last_nxt = done_after_pop;
          do_pop       = 1'b1;
          clear_ended  = done_after_pop;
          res_cnt_nxt  = res_cnt_r + RES_CNT_W'(1);
          scan_idx_nxt = '0;
          cmp_vld_nxt  = 1'b0;
          best_any_nxt = 1'b0;
          state_nxt    = ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: held until the transfer completes.
  always_comb begin
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cfg_ways_r   <= CFG_WAYS_RESET;
      ended_r      <= '0;
      scan_idx_r   <= '0;
      cmp_vld_r    <= 1'b0;
      cmp_way_r    <= '0;
      best_any_r   <= 1'b0;
      res_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
      for (int j = 0; j < WAYS; j++) begin
        fill_r[j] <= '0;
        head_r[j] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      scan_idx_r   <= scan_idx_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      cmp_way_r    <= cmp_way_nxt;
      best_any_r   <= best_any_nxt;
      res_cnt_r    <= res_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_ways_r <= cfg_data;
      end
      // Queue bookkeeping.
      if (do_write) begin
        fill_r[rec_idx] <= fill_r[rec_idx] + FW'(1);
      end
      if (do_pop) begin
        fill_r[best_way_r] <= fill_r[best_way_r] - FW'(1);
        head_r[best_way_r] <= (head_r[best_way_r] == QW'(QUEUE_DEPTH - 1))
                              ? '0 : head_r[best_way_r] + QW'(1);
      end
      // End marks: a finished merge clears all of them.
      if (clear_ended) begin
        ended_r <= '0;
      end else if (set_ended) begin
        ended_r[rec_idx] <= 1'b1;
      end
    end
  end

  // Record capture, best candidate and output payload.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rec_way_r  <= in_tdata[WAY_W-1:0];
      rec_key_r  <= in_tdata[WAY_W +: KEY_W];
      rec_pay_r  <= in_tdata[WAY_W + KEY_W +: PAYLOAD_BITS];
      rec_last_r <= in_tlast;
    end
    best_key_r <= best_key_nxt;
    best_way_r <= best_way_nxt;
    if (out_load) begin
      out_key_r  <= out_key_nxt;
      out_pay_r  <= out_pay_sel ? pay_rd_r : '0;
      out_last_r <= out_last_nxt;
      out_ovf_r  <= out_ovf_nxt;
    end
  end

  // Queue memories: one write port, registered reads.
  always_ff @(posedge clk) begin
    if (do_write) begin
      key_mem[{rec_idx, wr_slot}] <= rec_key_r;
      pay_mem[{rec_idx, wr_slot}] <= rec_pay_r;
    end
    key_rd_r <= key_mem[key_rd_addr];
    if (pay_rd_en) begin
      pay_rd_r <= pay_mem[{best_way_r, head_r[best_way_r]}];
    end
  end

  // Result stream.
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {PAY_W'(out_pay_r), out_key_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule

/* verif/kway_sorted_run_merger_tb.sv */
// ----------------------------------------------------------------------------
// kway_sorted_run_merger_tb: self-checking bench for the k-way run merger
// A driver streams records from a queue and a monitor checks every merged
// result against an in-bench merge predictor. The run covers a directed
// opening, then random sorted runs under several ways-in-use settings.
// ----------------------------------------------------------------------------
module kway_sorted_run_merger_tb;
  import kwm_pkg::*;

  localparam int WAYS         = 8;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUIET_CYCLES = 40;
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 32;

  typedef struct {
    logic [WAY_W-1:0] way;
    key_t             key;
    logic [PAY_W-1:0] payload;
    logic             last;
  } run_rec_t;

  typedef struct {
    key_t             key;
    logic [PAY_W-1:0] payload;
    logic             last;
    logic             overflow;
  } merged_rec_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // in_tdata: way, key, payload, zero pad.
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // out_tdata: out_key, out_payload.
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;

  // Stimulus and expected results.
  run_rec_t    records_to_send[$];
  merged_rec_t merged_expected[$];
  int          error_count = 0;
  int          idle_cycles = 0;
  int          run_rec_count = 0;

  // Predictor copy of the merger state.
  logic [CFG_W-1:0] way_count;
  key_t             q_key[WAYS][QUEUE_DEPTH];
  logic [PAY_W-1:0] q_pay[WAYS][QUEUE_DEPTH];
  int               q_fill[WAYS];
  int               q_head[WAYS];
  bit               way_done[WAYS];

  // Stream pacing.
  int in_gap     = 0;
  bit in_burst   = 1'b0;
  int out_stall  = 0;
  bit out_burst  = 1'b0;

  kway_sorted_run_merger #(
    .WAYS        (WAYS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PAYLOAD_BITS(PAY_W)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // A register value of 0 behaves as one way, values above WAYS as WAYS.
  function automatic int ways_taking_part(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > WAYS) return WAYS;
    return int'(v);
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Once every way in use has ended and drained, the merge is over and the
  // end marks clear for the next one.
  function automatic bit close_merge_if_done();
    int j;
    for (j = 0; j < ways_taking_part(way_count); j++) begin
      if (!way_done[j] || q_fill[j] != 0) return 1'b0;
    end
    for (j = 0; j < WAYS; j++) way_done[j] = 1'b0;
    return 1'b1;
  endfunction

  // Files one record and releases every record that becomes eligible.
  task automatic merge_record(input run_rec_t r);
    int          nw;
    int          n;
    int          j;
    int          best;
    int          slot;
    bit          any;
    bit          all_ready;
    key_t        best_key;
    merged_rec_t res;
    nw = ways_taking_part(way_count);
    n  = 0;
    if (int'(r.way) < nw && !way_done[r.way]) begin
      if (r.key == SENTINEL_KEY) begin
        if (r.last) way_done[r.way] = 1'b1;
      end else if (q_fill[r.way] >= QUEUE_DEPTH) begin
        res = '{key: '0, payload: '0, last: 1'b0, overflow: 1'b1};
        merged_expected.push_back(res);
        n++;
      end else begin
        slot = (q_head[r.way] + q_fill[r.way]) % QUEUE_DEPTH;
        q_key[r.way][slot] = r.key;
        q_pay[r.way][slot] = r.payload;
        q_fill[r.way]++;
        if (r.last) way_done[r.way] = 1'b1;
      end
    end
    while (n < MAX_RESULTS) begin
      any       = 1'b0;
      all_ready = 1'b1;
      best      = 0;
      best_key  = '0;
      for (j = 0; j < nw; j++) begin
        if (q_fill[j] == 0) begin
          if (!way_done[j]) all_ready = 1'b0;
        end else if (!any || q_key[j][q_head[j]] < best_key) begin
          best_key = q_key[j][q_head[j]];
          best     = j;
          any      = 1'b1;
        end
      end
      if (!all_ready || !any) break;
      res.key      = best_key;
      res.payload  = q_pay[best][q_head[best]];
      res.overflow = 1'b0;
      q_head[best] = (q_head[best] + 1) % QUEUE_DEPTH;
      q_fill[best]--;
      res.last = close_merge_if_done();
      merged_expected.push_back(res);
      n++;
    end
    void'(close_merge_if_done());
  endtask

  // Record driver: one record per transfer, with a random gap after each.
  always @(posedge clk) begin : record_driver
    run_rec_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        if ($urandom_range(0, 19) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 4);
      end
      if (in_gap > 0 || records_to_send.size() == 0) begin
        if (in_gap > 0) in_gap--;
        in_tvalid <= 1'b0;
      end else begin
        r = records_to_send.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {{(IN_TDATA_W - WAY_W - KEY_W - PAY_W){1'b0}}, r.payload, r.key, r.way};
        in_tlast  <= r.last;
      end
    end
  end

  // Result ready: after each transfer hold off for a random number of cycles.
  always @(posedge clk) begin : result_ready_gen
    int stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall  = 0;
    end else if (out_tvalid && out_tready) begin
      if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 4);
      out_stall  = stall;
      out_tready <= (stall == 0);
    end else if (out_stall > 0) begin
      out_stall--;
      out_tready <= (out_stall == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: check results, track the register, predict accepted records.
  always @(posedge clk) begin : merge_monitor
    merged_rec_t got;
    merged_rec_t want;
    run_rec_t    r;
    int          j;
    if (!rst_n) begin
      way_count = CFG_WAYS_RESET;
      for (j = 0; j < WAYS; j++) begin
        q_fill[j]   = 0;
        q_head[j]   = 0;
        way_done[j] = 1'b0;
      end
    end else begin
      if (out_tvalid && out_tready) begin
        got.key      = out_tdata[KEY_W-1:0];
        got.payload  = out_tdata[KEY_W +: PAY_W];
        got.last     = out_tlast;
        got.overflow = out_tuser;
        if (merged_expected.size() == 0) begin
          flag_error($sformatf("unexpected result key=%h pay=%h last=%b ovf=%b",
                               got.key, got.payload, got.last, got.overflow));
        end else begin
          want = merged_expected.pop_front();
          if (got.key !== want.key || got.payload !== want.payload ||
              got.last !== want.last || got.overflow !== want.overflow) begin
            flag_error($sformatf({"mismatch exp key=%h pay=%h last=%b ovf=%b",
                                  " got key=%h pay=%h last=%b ovf=%b"},
                                 want.key, want.payload, want.last, want.overflow,
                                 got.key, got.payload, got.last, got.overflow));
          end
        end
      end
      if (cfg_valid && cfg_ready) way_count = cfg_data;
      if (in_tvalid && in_tready) begin
        r.way     = in_tdata[WAY_W-1:0];
        r.key     = in_tdata[WAY_W +: KEY_W];
        r.payload = in_tdata[WAY_W + KEY_W +: PAY_W];
        r.last    = in_tlast;
        merge_record(r);
      end
    end
  end

  // Watchdog: give up when no transfer of any kind happens for too long.
  always @(posedge clk) begin : watchdog
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_rec(input logic [WAY_W-1:0] w, input key_t k,
                          input logic [PAY_W-1:0] p, input logic l);
    run_rec_t r;
    r = '{way: w, key: k, payload: p, last: l};
    records_to_send.push_back(r);
  endtask

  // Wait until the block has nothing left to send and has gone quiet.
  task automatic settle();
    do @(negedge clk);
    while (records_to_send.size() != 0 || in_tvalid || merged_expected.size() != 0);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_ways(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One merge: a sorted run per way, interleaved at random, with some noise.
  // A run ends either on its last record or on a trailing end sentinel.
  task automatic run_merge(input int nw);
    run_rec_t run_recs[$];
    run_rec_t r;
    int       first[WAYS];
    int       cnt[WAYS];
    int       taken[WAYS];
    int       len;
    int       left;
    int       j;
    int       i;
    int       key_mode;
    bit       broken;
    longint   k;
    longint   step;
    broken   = 1'b0;
    left     = 0;
    key_mode = $urandom_range(0, 2);
    for (j = 0; j < nw; j++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
      if (len > QUEUE_DEPTH) broken = 1'b1;
      first[j] = run_recs.size();
      taken[j] = 0;
      case (key_mode)
        0:       k = longint'($urandom_range(0, 7));
        1:       k = longint'($urandom() >> 1);
        default: k = 0;
      endcase
      for (i = 0; i < len; i++) begin
        r.way     = j[WAY_W-1:0];
        r.key     = k[KEY_W-1:0];
        r.payload = {$urandom(), $urandom()};
        r.last    = (i == len - 1);
        run_recs.push_back(r);
        case (key_mode)
          0:       step = longint'($urandom_range(0, 3));
          1:       step = longint'($urandom() >> $urandom_range(3, 31));
          default: step = $urandom_range(0, 1) ? 0 : 64'h7FFF_FFFF;
        endcase
        k = k + step;
        if (k >= longint'(SENTINEL_KEY)) k = longint'(SENTINEL_KEY) - 1;
      end
      // Sometimes close the run with an end sentinel instead.
      if (len == 0 || $urandom_range(0, 3) == 0) begin
        if (len > 0) run_recs[run_recs.size() - 1].last = 1'b0;
        r.way     = j[WAY_W-1:0];
        r.key     = SENTINEL_KEY;
        r.payload = {$urandom(), $urandom()};
        r.last    = 1'b1;
        run_recs.push_back(r);
      end
      cnt[j] = run_recs.size() - first[j];
      left  += cnt[j];
    end
    while (left > 0) begin
      j = $urandom_range(0, nw - 1);
      if (taken[j] == cnt[j]) continue;
      if ($urandom_range(0, 11) == 0) begin
        broken = 1'b1;
        push_rec(WAY_W'($urandom_range(0, WAYS - 1)),
                 $urandom_range(0, 3) == 0 ? SENTINEL_KEY : key_t'($urandom()),
                 {$urandom(), $urandom()}, 1'($urandom_range(0, 1)));
      end
      records_to_send.push_back(run_recs[first[j] + taken[j]]);
      taken[j]++;
      left--;
      run_rec_count++;
    end
    // A disturbed merge may be stuck; ending every way flushes it.
    if (broken) begin
      for (j = 0; j < nw; j++) push_rec(j[WAY_W-1:0], SENTINEL_KEY, '0, 1'b1);
    end
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] ways_plan[8];
    int               p;
    int               j;
    int               start;
    ways_plan = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd5, 4'd2, 4'd6, 4'd8};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening with all eight ways in use. Way 0 fills its queue
    // while the others are empty, so a fifth record overflows.
    push_rec(0, 32'd0, '1, 1'b0);
    push_rec(0, 32'd5, '0, 1'b0);
    push_rec(0, 32'd6, 64'h0123_4567_89AB_CDEF, 1'b0);
    push_rec(0, 32'd7, 64'hFEDC_BA98_7654_3210, 1'b0);
    push_rec(0, 32'd8, 64'h5555_AAAA_5555_AAAA, 1'b0);
    // A sentinel without the last flag is simply dropped.
    push_rec(1, SENTINEL_KEY, '1, 1'b0);
    push_rec(1, SENTINEL_KEY, '0, 1'b1);
    // Way 1 has ended, so this record is ignored.
    push_rec(1, 32'd3, 64'hAAAA_5555_AAAA_5555, 1'b1);
    // Way 2 ties with way 0 on key 5; the lower way goes first.
    push_rec(2, 32'd5, 64'h1111_2222_3333_4444, 1'b1);
    for (j = 3; j < 7; j++) push_rec(j[WAY_W-1:0], SENTINEL_KEY, '0, 1'b1);
    push_rec(7, 32'hFFFF_FFFE, '0, 1'b1);
    push_rec(0, SENTINEL_KEY, '1, 1'b1);
    // Next merge ends on a sentinel after its only record has left.
    for (j = 0; j < 7; j++) push_rec(j[WAY_W-1:0], SENTINEL_KEY, '1, 1'b1);
    push_rec(7, 32'd100, 64'hDEAD_BEEF_0000_FFFF, 1'b0);
    push_rec(7, SENTINEL_KEY, '0, 1'b1);
    settle();

    for (p = 0; p < 8; p++) begin
      write_ways(ways_plan[p]);
      start = run_rec_count;
      while (run_rec_count - start < PHASE_ITEMS) run_merge(ways_taking_part(ways_plan[p]));
      // Strand records in the upper ways before the count shrinks.
      if (ways_plan[p] == 4'd15) begin
        for (j = 4; j < WAYS; j++) begin
          push_rec(j[WAY_W-1:0], key_t'($urandom_range(0, 1000)), {$urandom(), $urandom()}, 1'b0);
        end
      end
      settle();
    end

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/kwm_pkg.sv
hdl/kway_sorted_run_merger.sv
verif/kway_sorted_run_merger_tb.sv
